@@ design/soft_timer_table_macros.svh @@
// Assertion macros for the soft timer table RTL.
`ifndef SOFT_TIMER_TABLE_MACROS_SVH
`define SOFT_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define STT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk, off during reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/stt_pkg.sv @@
// Constants and codes for the soft timer table.
package stt_pkg;

    // table geometry
    localparam int NUM_TIMERS = 20;
    localparam int TIME_BITS  = 32;
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int HANDLE_W   = 5;
    localparam int IDX_W      = 5;

    // one table entry: period in the upper half, start time in the lower
    localparam int ENTRY_W    = 2 * TIME_BITS;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd2;

endpackage

@@ design/stt_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
module stt_ram #(
    parameter int DEPTH  = 20,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered: data valid in the cycle after the enable
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/soft_timer_table.sv @@
// Soft timer table top level: tick counter, timer allocation and polling.
//
// Input channel: i_valid / o_stall with i_operation, i_interval and
// i_timer_index. An item is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with o_status, o_handle,
// o_fired and o_time_now; one result per item, in order.
// Each item passes S_IDLE and S_PROC: the accept cycle issues the read
// of the addressed entry of the timer RAM; in S_PROC the block compares,
// writes the entry back and loads the output register. No new item is
// taken until the last one leaves S_PROC; o_valid rises as it does so.
// The output register lets the next item be taken while a result waits.
// If the receiver still stalls that result when the next item finishes,
// the block holds that item in its work cycle and keeps o_stall high.
// Reset clears the tick counter, the allocation count and the handshake
// state. The timer RAM is not cleared: a slot is only read once created,
// so no clearing pass is needed and the block is ready right after reset.
`include "soft_timer_table_macros.svh"

module soft_timer_table
    import stt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [TIME_BITS-1:0] i_interval,
    input  logic [IDX_W-1:0]    i_timer_index,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle,
    output logic                o_fired,
    output logic [TIME_BITS-1:0] o_time_now
);

    typedef enum logic {
        S_IDLE,
        S_PROC
    } t_state;

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [TIME_BITS-1:0] r_interval;
    logic                 r_idx_ok;
    logic [ADDR_W-1:0]    r_addr;
    logic [TIME_BITS-1:0] r_tick;
    logic [CNT_W-1:0]     r_used;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [HANDLE_W-1:0]  r_handle;
    logic                 r_fired;

    logic                 in_accept;
    logic                 idx_ok;
    logic                 done;
    logic                 table_full;
    logic [ENTRY_W-1:0]   rd_data;
    logic [TIME_BITS-1:0] ent_period;
    logic [TIME_BITS-1:0] ent_start;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expire;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    logic [TIME_BITS-1:0] n_tick;
    logic [CNT_W-1:0]     n_used;
    logic [STATUS_W-1:0]  n_status;
    logic [HANDLE_W-1:0]  n_handle;
    logic                 n_fired;

    // handshake
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign done      = (r_state == S_PROC) && (!r_out_valid || !i_stall);

    // handle in range of the allocated slots (also bounds the RAM address)
    assign idx_ok = (32'(i_timer_index) < 32'(r_used));

    // Reads happen only on accept edges and writes only on completing
    // edges, which never coincide, so a read always sees earlier writes.
    stt_ram #(
        .DEPTH  (NUM_TIMERS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept && (i_operation == OP_CHECK) && idx_ok),
        .i_rd_addr (i_timer_index[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // compare the stored entry against now
    assign ent_period = rd_data[ENTRY_W-1:TIME_BITS];
    assign ent_start  = rd_data[TIME_BITS-1:0];
    assign elapsed    = r_tick - ent_start;
    assign expire     = (elapsed > ent_period);
    assign table_full = (32'(r_used) >= 32'(NUM_TIMERS));

    // per-operation result and write-back
    always_comb begin
        n_tick   = r_tick;
        n_used   = r_used;
        n_status = ST_OK;
        n_handle = '0;
        n_fired  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = {ent_period, r_tick};
        case (r_op)
            OP_TICK: begin
                n_tick = r_tick + TIME_BITS'(1);
            end
            OP_CREATE: begin
                if (table_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_used   = r_used + CNT_W'(1);
                    n_handle = HANDLE_W'(r_used);
                    wr_en    = done;
                    wr_addr  = r_used[ADDR_W-1:0];
                    wr_data  = {r_interval, r_tick};
                end
            end
            OP_CHECK: begin
                if (!r_idx_ok) begin
                    n_status = ST_UNALLOC;
                end else if (expire) begin
                    n_fired = 1'b1;
                    wr_en   = done;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer, state registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result valid: set by a finished item, cleared when taken
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op       <= i_operation;
                        r_interval <= i_interval;
                        r_idx_ok   <= idx_ok;
                        r_addr     <= i_timer_index[ADDR_W-1:0];
                        r_state    <= S_PROC;
                    end
                end
                S_PROC: begin
                    if (done) begin
                        r_tick      <= n_tick;
                        r_used      <= n_used;
                        r_status    <= n_status;
                        r_handle    <= n_handle;
                        r_fired     <= n_fired;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_handle   = r_handle;
    assign o_fired    = r_fired;
    assign o_time_now = r_tick;

    // checks
    `STT_ASSERT_IMPL(a_used_bound, 1'b1, 32'(r_used) <= 32'(NUM_TIMERS), "slot count past table")
    `STT_ASSERT_NEXT(a_accept_proc, in_accept, r_state == S_PROC, "accept did not start work")
    `STT_ASSERT_NEXT(a_done_out, done, o_valid && (r_state == S_IDLE), "finished item not shown")
    `STT_ASSERT_NEXT(a_create_inc, done && (r_op == OP_CREATE) && !table_full, r_used == $past(r_used) + CNT_W'(1), "create did not take a slot")

endmodule
